>>> hdl/bba_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the buddy block allocator
package bba_pkg;

	localparam int unsigned MAX_ARENA_ORDER_DEF = 16;
	localparam int unsigned MIN_ORDER_DEF       = 4;
	localparam int unsigned HEADER_BYTES_DEF    = 2;

	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARENA_ORDER = 1'b0,
		REG_FIT_SEL     = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_NO_FIT  = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_RD,
		S_WALK,
		S_SPLIT,
		S_MARK,
		S_FREE_RD,
		S_FREE_CHK,
		S_BUD_RD,
		S_BUD_CHK,
		S_RESP
	} state_t;

endpackage

>>> hdl/buddy_block_allocator.sv
`timescale 1ns / 1ps
// buddy block allocator: header memory, walk/split/merge sequencer
//
// channel  dir  beat contents
// s_axis   in   tuser: op; tdata: req_bytes, free_offset
// m_axis   out  tdata: status, payload_offset, block_order
// cfg      in   index 0 arena_order, index 1 fit selection
//
// an allocate visits blocks in address order (best and worst fit visit
// every block), then splits the chosen block and marks it busy; a free
// walks the blocks up to the target, then tries merges with its buddy.
// header reads use the read port and writes a separate write port of the header memory.
// the arena is one free block after reset or an arena_order write; no
// clearing pass. input is not ready while a request is in work or its
// result waits at the output register.
module buddy_block_allocator #(
	parameter int unsigned MAX_ARENA_ORDER = bba_pkg::MAX_ARENA_ORDER_DEF,
	parameter int unsigned MIN_ORDER       = bba_pkg::MIN_ORDER_DEF,
	parameter int unsigned HEADER_BYTES    = bba_pkg::HEADER_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// op [0]
	input  logic                           s_axis_tuser,
	// req_bytes [15:0], free_offset [31:16]
	input  logic [31:0]                    s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status [1:0], payload_offset [17:2], block_order [22:18], zero fill to 24
	output logic [23:0]                    m_axis_tdata
);
	import bba_pkg::*;

	localparam int unsigned GRAN_W = MAX_ARENA_ORDER - MIN_ORDER;
	localparam int unsigned DEPTH  = 1 << GRAN_W;
	localparam int unsigned OFF_W  = MAX_ARENA_ORDER + 1;
	localparam int unsigned ORD_W  = 6;

	typedef struct packed {
		logic             busy;
		logic [ORD_W-1:0] order;
	} hdr_t;

	state_t state_q, state_d;
	logic [ORD_W-1:0] arena_order_q;
	logic [1:0]       fit_sel_q;
	logic             root_valid_q;

	op_t              op_q;
	logic [16:0]      bytes_q;
	logic [15:0]      free_off_q;
	logic [ORD_W-1:0] need_q;
	logic [OFF_W-1:0] off_q;
	logic [OFF_W-1:0] best_q;
	logic [ORD_W-1:0] best_ord_q;
	logic             found_q;
	logic [OFF_W-1:0] target_q;
	logic [ORD_W-1:0] o_q;

	logic [1:0]       res_status_q;
	logic [15:0]      res_pay_q;
	logic [4:0]       res_ord_q;
	logic             res_valid_q;

	hdr_t             mem [DEPTH];
	hdr_t             rd_raw_q;
	logic             rd_root_q;
	hdr_t             rd_hdr;
	logic [GRAN_W-1:0] rd_addr;
	logic             mem_we;
	logic [GRAN_W-1:0] wr_addr;
	hdr_t             wr_data;

	logic [ORD_W-1:0] cfg_ord;
	logic [OFF_W-1:0] arena_sz;
	logic [ORD_W-1:0] need_calc;
	logic             s_acc;
	logic [OFF_W-1:0] next_off;
	logic             take;
	logic [OFF_W-1:0] buddy;
	logic [OFF_W-1:0] split_off;
	logic [ORD_W-1:0] split_ord;

	function automatic logic [GRAN_W-1:0] gran(input logic [OFF_W-1:0] a);
		gran = a[MIN_ORDER +: GRAN_W];
	endfunction

	always_comb begin
		if (cfg_wdata < MIN_ORDER)
			cfg_ord = ORD_W'(MIN_ORDER);
		else if (cfg_wdata > MAX_ARENA_ORDER)
			cfg_ord = ORD_W'(MAX_ARENA_ORDER);
		else
			cfg_ord = ORD_W'(cfg_wdata);
	end

	assign arena_sz = OFF_W'(1) << arena_order_q;
	assign s_axis_tready = (state_q == S_IDLE) && !res_valid_q;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// needed order: one above the leading-one position of (bytes + header - 1), at least MIN_ORDER
	always_comb begin
		logic [16:0] m;
		m = bytes_q - 17'd1;
		need_calc = '0;
		for (int i = 0; i < 17; i++)
			if (m[i])
				need_calc = ORD_W'(i + 1);
		if (bytes_q <= 17'd1)
			need_calc = '0;
		if (need_calc < MIN_ORDER)
			need_calc = ORD_W'(MIN_ORDER);
	end

	// granule zero reads as the whole free arena until first written
	assign rd_hdr = rd_root_q ? hdr_t'{busy: 1'b0, order: arena_order_q} : rd_raw_q;
	assign next_off = off_q + (OFF_W'(1) << rd_hdr.order);
	assign buddy = target_q ^ (OFF_W'(1) << o_q);
	assign split_ord = best_ord_q - ORD_W'(1);
	assign split_off = best_q + (OFF_W'(1) << split_ord);

	always_comb begin
		take = !found_q;
		if (fit_sel_q == FIT_BEST && rd_hdr.order < best_ord_q)
			take = 1'b1;
		if (fit_sel_q == FIT_WORST && rd_hdr.order > best_ord_q)
			take = 1'b1;
	end

	always_comb begin
		unique case (state_q)
			S_FREE_RD: rd_addr = gran(off_q);
			S_BUD_RD:  rd_addr = gran(buddy);
			default:   rd_addr = gran(off_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[wr_addr] <= wr_data;
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_root_q <= 1'b0;
		else
			rd_root_q <= (rd_addr == '0) && root_valid_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (s_acc)
					state_d = (s_axis_tuser == OP_FREE) ? S_FREE_RD : S_WALK_RD;
			S_WALK_RD:
				state_d = (need_calc > arena_order_q) ? S_RESP : S_WALK;
			S_WALK: begin
				if (off_q >= arena_sz)
					state_d = found_q ? S_SPLIT : S_RESP;
				else if (!rd_hdr.busy && rd_hdr.order >= need_q && take &&
				         fit_sel_q != FIT_BEST && fit_sel_q != FIT_WORST)
					state_d = S_SPLIT;
				else
					state_d = S_WALK_RD;
			end
			S_SPLIT:
				if (best_ord_q <= need_q)
					state_d = S_MARK;
			S_MARK:   state_d = S_RESP;
			S_FREE_RD:
				state_d = (free_off_q < HEADER_BYTES || off_q >= arena_sz ||
				           off_q > target_q) ? S_RESP : S_FREE_CHK;
			S_FREE_CHK:
				if (off_q == target_q)
					state_d = rd_hdr.busy ? S_BUD_RD : S_RESP;
				else
					state_d = S_FREE_RD;
			S_BUD_RD:
				state_d = (o_q >= arena_order_q || buddy >= arena_sz) ? S_RESP : S_BUD_CHK;
			S_BUD_CHK:
				state_d = (rd_hdr.busy || rd_hdr.order != o_q) ? S_RESP : S_BUD_RD;
			S_RESP:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory writes
	always_comb begin
		mem_we  = 1'b0;
		wr_addr = gran(best_q);
		wr_data = hdr_t'{busy: 1'b0, order: split_ord};
		unique case (state_q)
			S_SPLIT:
				if (best_ord_q > need_q) begin
					mem_we  = 1'b1;
					wr_addr = gran(split_off);
				end
			S_MARK: begin
				mem_we  = 1'b1;
				wr_data = hdr_t'{busy: 1'b1, order: best_ord_q};
			end
			S_FREE_CHK:
				if (off_q == target_q && rd_hdr.busy) begin
					mem_we  = 1'b1;
					wr_addr = gran(target_q);
					wr_data = hdr_t'{busy: 1'b0, order: rd_hdr.order};
				end
			S_BUD_CHK:
				if (!rd_hdr.busy && rd_hdr.order == o_q) begin
					mem_we  = 1'b1;
					wr_addr = gran(target_q & buddy);
					wr_data = hdr_t'{busy: 1'b0, order: o_q + ORD_W'(1)};
				end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			arena_order_q <= ORD_W'(MAX_ARENA_ORDER < 16 ? MAX_ARENA_ORDER : 16);
			fit_sel_q     <= FIT_FIRST;
			root_valid_q  <= 1'b1;
			res_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we && cfg_index == REG_ARENA_ORDER) begin
				arena_order_q <= cfg_ord;
				root_valid_q  <= 1'b1;
			end else if (mem_we && wr_addr == '0) begin
				root_valid_q  <= 1'b0;
			end
			if (cfg_we && cfg_index == REG_FIT_SEL)
				fit_sel_q <= cfg_wdata[1:0];
			if (state_q == S_RESP)
				res_valid_q <= 1'b1;
			else if (m_axis_tready)
				res_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE:
				if (s_acc) begin
					op_q       <= op_t'(s_axis_tuser);
					bytes_q    <= {1'b0, s_axis_tdata[15:0]} + 17'(HEADER_BYTES);
					free_off_q <= s_axis_tdata[31:16];
					target_q   <= OFF_W'(s_axis_tdata[31:16]) - OFF_W'(HEADER_BYTES);
					off_q      <= '0;
					found_q    <= 1'b0;
					best_q     <= '0;
					best_ord_q <= '0;
				end
			S_WALK_RD: need_q <= need_calc;
			S_WALK:
				if (off_q < arena_sz) begin
					if (!rd_hdr.busy && rd_hdr.order >= need_q && take) begin
						best_q     <= off_q;
						best_ord_q <= rd_hdr.order;
						found_q    <= 1'b1;
					end
					off_q <= next_off;
				end
			S_SPLIT:
				if (best_ord_q > need_q)
					best_ord_q <= split_ord;
			S_FREE_CHK: begin
				off_q <= next_off;
				o_q   <= rd_hdr.order;
				// free hit flag reuses found_q
				if (off_q == target_q && rd_hdr.busy)
					found_q <= 1'b1;
			end
			S_BUD_CHK:
				if (!rd_hdr.busy && rd_hdr.order == o_q) begin
					target_q <= target_q & buddy;
					o_q      <= o_q + ORD_W'(1);
				end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_RESP) begin
			if (op_q == OP_ALLOC) begin
				if (found_q && need_q <= arena_order_q) begin
					res_status_q <= ST_DONE;
					res_pay_q    <= 16'(best_q + OFF_W'(HEADER_BYTES));
					res_ord_q    <= 5'(best_ord_q);
				end else begin
					res_status_q <= ST_NO_FIT;
					res_pay_q    <= '0;
					res_ord_q    <= '0;
				end
			end else if (found_q) begin
				res_status_q <= ST_DONE;
				res_pay_q    <= '0;
				res_ord_q    <= 5'(o_q);
			end else begin
				res_status_q <= ST_IGNORED;
				res_pay_q    <= '0;
				res_ord_q    <= '0;
			end
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {1'b0, res_ord_q, res_pay_q, res_status_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_axis_tready)
		else $error("accept while busy");
	a_resp_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |=> m_axis_tvalid)
		else $error("result lost");
	a_split_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (best_ord_q == need_q))
		else $error("split overshoot");

endmodule
